@@ sv/stg_pkg.sv @@
// stg_pkg: constants, widths and shared types of the square tone generator
// no dependencies; imported by every module of the block

package stg_pkg;

	// sample clock of the audio path in hertz
	localparam int SAMPLE_RATE = 16000;

	// loudness and timing constants
	localparam int FULL_SCALE = 12000;
	localparam int VOL_MAX    = 100;
	localparam int MS_PER_S   = 1000;
	localparam int FADE_DIV   = 200;
	localparam int AMP_STEP   = FULL_SCALE / VOL_MAX;
	localparam int FADE_LEN   = SAMPLE_RATE / FADE_DIV;

	// field widths
	localparam int FREQ_W   = 16;
	localparam int DUR_W    = 16;
	localparam int VOL_W    = 8;
	localparam int DATA_W   = 16;
	localparam int SMP_W    = 15;
	localparam int REG_IDX_W = 2;

	// derived widths
	localparam int SR_W      = $clog2(SAMPLE_RATE + 1);
	localparam longint MAX_TOTAL = (longint'(SAMPLE_RATE) * 65535) / MS_PER_S;
	localparam int CNT_W     = $clog2(MAX_TOTAL + 1);
	localparam int HALF_W    = $clog2(SAMPLE_RATE / 2 + 1);
	localparam int PHASE_W   = HALF_W + 1;
	localparam int AMP_W     = $clog2(FULL_SCALE + 1);
	localparam int VCAP_W    = $clog2(VOL_MAX + 1);
	localparam int K_W       = $clog2(FADE_LEN);
	localparam int X_W       = AMP_W + K_W;

	// envelope divide by FADE_LEN as a multiply by a rounded-up reciprocal
	localparam int RECIP_SHIFT = 32;
	localparam longint RECIP   = ((longint'(1) << RECIP_SHIFT) / FADE_LEN) + 1;
	localparam int RECIP_W     = $clog2(RECIP + 1);
	localparam int RP_W        = X_W + RECIP_W;

	// iterative divider
	localparam int DIVD_W    = SR_W + DUR_W;
	localparam int DIVS_W    = FREQ_W + 1;
	localparam int DIV_CNT_W = $clog2(DIVD_W);

	// sample count divide by MS_PER_S as a multiply by a rounded-up reciprocal
	localparam int     TOT_SHIFT   = DIVD_W + $clog2(MS_PER_S);
	localparam longint TOT_RECIP   = ((longint'(1) << TOT_SHIFT) / MS_PER_S) + 1;
	localparam int     TOT_RECIP_W = $clog2(TOT_RECIP + 1);
	localparam int     TOT_P_W     = DIVD_W + TOT_RECIP_W;

	// queue depths
	localparam int CMDQ_DEPTH = 2;
	localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
	localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);
	localparam int RQ_DEPTH   = 2;
	localparam int RQ_PTR_W   = $clog2(RQ_DEPTH);
	localparam int RQ_CNT_W   = $clog2(RQ_DEPTH + 1);

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_FREQ   = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_DUR    = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_VOL    = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_ENABLE = 2'd3;

	typedef struct packed {
		logic [FREQ_W-1:0] freq;
		logic [DUR_W-1:0]  dur;
		logic [VOL_W-1:0]  vol;
		logic              en;
	} cfg_t;

	// classified word between front and back
	typedef struct packed {
		logic              start;
		logic              silent;
		logic [AMP_W-1:0]  peak;
		logic [DUR_W-1:0]  dur;
		logic [FREQ_W-1:0] freq;
	} cmd_t;

	typedef struct packed {
		logic signed [SMP_W-1:0] sample;
		logic                    last;
		logic                    active;
	} rslt_t;

	typedef struct packed {
		logic              start;
		logic [DIVD_W-1:0] dividend;
		logic [DIVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIVD_W-1:0] quot;
	} div_rsp_t;

endpackage

@@ sv/stg_front.sv @@
// stg_front: accepts input words, classifies them and queues commands
// depends on stg_pkg

module stg_front import stg_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  logic start_tone,
	output logic full,
	input  cfg_t cfg,
	input  logic cmd_pop,
	output logic cmd_valid,
	output cmd_t cmd
);

	cmd_t                  cmdq_q [CMDQ_DEPTH];
	logic [CMDQ_PTR_W-1:0] wr_ptr_q;
	logic [CMDQ_PTR_W-1:0] rd_ptr_q;
	logic [CMDQ_CNT_W-1:0] cnt_q;
	logic                  wr_fire;
	logic                  rd_fire;
	logic [VCAP_W-1:0]     vol_cap;
	cmd_t                  cmd_new;

	// saturate volume, scale to peak, flag silent tones
	always_comb begin
		vol_cap = (cfg.vol > VOL_W'(VOL_MAX)) ? VCAP_W'(VOL_MAX) : cfg.vol[VCAP_W-1:0];
		cmd_new.start  = start_tone;
		cmd_new.silent = !cfg.en || (cfg.freq == '0) || (cfg.dur == '0);
		cmd_new.peak   = AMP_W'(vol_cap) * AMP_W'(AMP_STEP);
		cmd_new.dur    = cfg.dur;
		cmd_new.freq   = cfg.freq;
	end

	assign full      = (cnt_q == CMDQ_CNT_W'(CMDQ_DEPTH));
	assign cmd_valid = (cnt_q != '0);
	assign cmd       = cmdq_q[rd_ptr_q];
	assign wr_fire   = push && !full;
	assign rd_fire   = cmd_pop && cmd_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_fire) begin
				wr_ptr_q <= (wr_ptr_q == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_fire) begin
				rd_ptr_q <= (rd_ptr_q == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_fire && !rd_fire) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd_fire && !wr_fire) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_fire) begin
			cmdq_q[wr_ptr_q] <= cmd_new;
		end
	end

endmodule

@@ sv/stg_div.sv @@
// stg_div: restoring divider, one quotient bit per cycle
// depends on stg_pkg

module stg_div import stg_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIVS_W-1:0]    rem_q;
	logic [DIVD_W-1:0]    quo_q;
	logic [DIVS_W-1:0]    dvs_q;
	logic [DIVS_W:0]      trial;
	logic [DIVS_W:0]      diff;
	logic                 ge;

	always_comb begin
		trial = {rem_q, quo_q[DIVD_W-1]};
		diff  = trial - {1'b0, dvs_q};
		ge    = (trial >= {1'b0, dvs_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.dividend;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
			quo_q <= {quo_q[DIVD_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;

endmodule

@@ sv/stg_back.sv @@
// stg_back: tone sequencer; latches tone setup, runs the envelope and phase
// depends on stg_pkg; drives stg_div and feeds the result queue

module stg_back import stg_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cmd_valid,
	input  cmd_t     cmd,
	output logic     cmd_pop,
	output div_req_t div_req,
	input  div_rsp_t div_rsp,
	input  logic     rslt_full,
	output logic     rslt_push,
	output rslt_t    rslt
);

	localparam logic [2:0] ST_IDLE      = 3'd0;
	localparam logic [2:0] ST_TOT_GO    = 3'd1;
	localparam logic [2:0] ST_TOT_WAIT  = 3'd2;
	localparam logic [2:0] ST_HALF_GO   = 3'd3;
	localparam logic [2:0] ST_HALF_WAIT = 3'd4;
	localparam logic [2:0] ST_ENV1      = 3'd5;
	localparam logic [2:0] ST_ENV2      = 3'd6;
	localparam logic [2:0] ST_EMIT      = 3'd7;

	logic [2:0]         state_q;
	cmd_t               cmd_q;
	logic               running_q;
	logic               silent_q;
	logic [AMP_W-1:0]   peak_q;
	logic [CNT_W-1:0]   idx_q;
	logic [CNT_W-1:0]   total_q;
	logic [HALF_W-1:0]  half_q;
	logic [PHASE_W-1:0] phase_q;
	logic [DIVD_W-1:0]  tot_prod_q;

	logic [X_W-1:0]     prod_s1;
	logic               full_s1;
	logic [RP_W-1:0]    recip_s2;
	logic               full_s2;

	logic [RECIP_W-1:0] recip_c;
	logic               fade_in;
	logic               fade_out;
	logic [CNT_W-1:0]   remain;
	logic [K_W-1:0]     k;
	logic [AMP_W-1:0]   env;
	logic [SMP_W-1:0]   mag;
	logic [PHASE_W-1:0] phase_inc;
	logic [PHASE_W-1:0] phase_nxt;
	logic [CNT_W-1:0]   idx_inc;
	logic [TOT_P_W-1:0] tot_full;
	logic [CNT_W-1:0]   tot_cnt;

	assign recip_c  = RECIP_W'(RECIP);

	// sample count: rate times duration, then divide by 1000 through the reciprocal
	assign tot_full = TOT_P_W'(tot_prod_q) * TOT_P_W'(TOT_RECIP);
	assign tot_cnt  = tot_full[TOT_SHIFT +: CNT_W];

	// fade position
	always_comb begin
		remain   = total_q - idx_q;
		fade_in  = (idx_q < CNT_W'(FADE_LEN));
		fade_out = (total_q > CNT_W'(FADE_LEN)) &&
			(idx_q > (total_q - CNT_W'(FADE_LEN)));
		k = fade_in ? idx_q[K_W-1:0] : remain[K_W-1:0];
	end

	// sample and next phase
	always_comb begin
		env       = full_s2 ? peak_q : recip_s2[RECIP_SHIFT +: AMP_W];
		mag       = SMP_W'(env);
		phase_inc = phase_q + 1'b1;
		phase_nxt = (phase_inc >= {half_q, 1'b0}) ? '0 : phase_inc;
		idx_inc   = idx_q + 1'b1;
		rslt.sample = '0;
		rslt.last   = 1'b0;
		rslt.active = 1'b0;
		if (running_q) begin
			if (!silent_q) begin
				rslt.sample = (phase_q < PHASE_W'(half_q)) ? mag : -mag;
			end
			rslt.last   = (idx_inc >= total_q);
			rslt.active = 1'b1;
		end
	end

	// divider request: half period
	always_comb begin
		div_req.start    = (state_q == ST_HALF_GO);
		div_req.dividend = DIVD_W'(SAMPLE_RATE);
		div_req.divisor  = {cmd_q.freq, 1'b0};
	end

	assign cmd_pop   = (state_q == ST_IDLE) && cmd_valid;
	assign rslt_push = (state_q == ST_EMIT) && !rslt_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			running_q <= 1'b0;
			silent_q  <= 1'b0;
			peak_q    <= '0;
			idx_q     <= '0;
			total_q   <= '0;
			half_q    <= '0;
			phase_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						if (cmd.start) begin
							silent_q  <= cmd.silent;
							peak_q    <= cmd.peak;
							phase_q   <= '0;
							idx_q     <= '0;
							running_q <= 1'b0;
							state_q   <= ST_TOT_GO;
						end else begin
							state_q <= ST_ENV1;
						end
					end
				end
				ST_TOT_GO: begin
					state_q <= ST_TOT_WAIT;
				end
				ST_TOT_WAIT: begin
					total_q   <= tot_cnt;
					running_q <= (tot_cnt != '0);
					if (cmd_q.freq == '0) begin
						half_q  <= '0;
						state_q <= ST_ENV1;
					end else begin
						state_q <= ST_HALF_GO;
					end
				end
				ST_HALF_GO: begin
					state_q <= ST_HALF_WAIT;
				end
				ST_HALF_WAIT: begin
					if (div_rsp.done) begin
						half_q  <= div_rsp.quot[HALF_W-1:0];
						state_q <= ST_ENV1;
					end
				end
				ST_ENV1: begin
					state_q <= ST_ENV2;
				end
				ST_ENV2: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (!rslt_full) begin
						if (running_q) begin
							if (!silent_q && (half_q != '0)) begin
								phase_q <= phase_nxt;
							end
							idx_q <= idx_inc;
							if (idx_inc >= total_q) begin
								running_q <= 1'b0;
							end
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cmd_q <= cmd;
		end
		if (state_q == ST_TOT_GO) begin
			tot_prod_q <= DIVD_W'(SAMPLE_RATE) * DIVD_W'(cmd_q.dur);
		end
		if (state_q == ST_ENV1) begin
			prod_s1 <= X_W'(peak_q) * X_W'(k);
			full_s1 <= !fade_in && !fade_out;
		end
		if (state_q == ST_ENV2) begin
			recip_s2 <= RP_W'(prod_s1) * RP_W'(recip_c);
			full_s2  <= full_s1;
		end
	end

endmodule

@@ sv/stg_rslt_q.sv @@
// stg_rslt_q: two-entry result queue between the sequencer and the output port
// depends on stg_pkg

module stg_rslt_q import stg_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr,
	input  rslt_t wr_data,
	output logic  wr_full,
	input  logic  rd,
	output logic  rd_empty,
	output rslt_t rd_data
);

	rslt_t               rq_q [RQ_DEPTH];
	logic [RQ_PTR_W-1:0] wr_ptr_q;
	logic [RQ_PTR_W-1:0] rd_ptr_q;
	logic [RQ_CNT_W-1:0] cnt_q;
	logic                wr_fire;
	logic                rd_fire;

	assign wr_full  = (cnt_q == RQ_CNT_W'(RQ_DEPTH));
	assign rd_empty = (cnt_q == '0);
	assign rd_data  = rq_q[rd_ptr_q];
	assign wr_fire  = wr && !wr_full;
	assign rd_fire  = rd && !rd_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_fire) begin
				wr_ptr_q <= (wr_ptr_q == RQ_PTR_W'(RQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_fire) begin
				rd_ptr_q <= (rd_ptr_q == RQ_PTR_W'(RQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_fire && !rd_fire) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd_fire && !wr_fire) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_fire) begin
			rq_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

@@ sv/square_tone_generator_with_fade_top.sv @@
// square_tone_generator_with_fade_top: square-wave tone generator with linear fade
// depends on stg_pkg, stg_front, stg_div, stg_back, stg_rslt_q
//
// channel   | handshake          | word
// ----------+--------------------+--------------------------------------------
// input     | push / full        | start_tone
// result    | empty / pop        | sample_value, last_sample, tone_active
// config    | wr_en (no wait)    | wr_index, wr_data
//
// a tick word passes through the sequencer as command pop, fade multiply,
// reciprocal multiply, emit into the result queue
// a start word adds the sample count (product, then reciprocal multiply)
// and, unless the frequency is zero, one run of the bit-serial divider
// for the half period
// a two-word command queue and a two-word result queue let input and output
// stall on their own; reset clears config registers (volume to 100) and tone state

module square_tone_generator_with_fade_top import stg_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	// input words
	input  logic                    push,
	output logic                    full,
	input  logic                    start_tone,
	// result words
	output logic                    empty,
	input  logic                    pop,
	output logic signed [SMP_W-1:0] sample_value,
	output logic                    last_sample,
	output logic                    tone_active,
	// configuration writes
	input  logic                    wr_en,
	input  logic [REG_IDX_W-1:0]    wr_index,
	input  logic [DATA_W-1:0]       wr_data
);

	cfg_t     cfg_q;
	logic     cmd_valid;
	logic     cmd_pop;
	cmd_t     cmd;
	div_req_t div_req;
	div_rsp_t div_rsp;
	logic     rslt_full;
	logic     rslt_push;
	rslt_t    rslt;
	rslt_t    head;

	// configuration registers; user writes only when no tone word is in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.freq <= '0;
			cfg_q.dur  <= '0;
			cfg_q.vol  <= VOL_W'(VOL_MAX);
			cfg_q.en   <= 1'b0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_FREQ:   cfg_q.freq <= wr_data[FREQ_W-1:0];
				REG_DUR:    cfg_q.dur  <= wr_data[DUR_W-1:0];
				REG_VOL:    cfg_q.vol  <= wr_data[VOL_W-1:0];
				REG_ENABLE: cfg_q.en   <= wr_data[0];
				default:    cfg_q      <= cfg_q;
			endcase
		end
	end

	// front: accept and classify, snapshot tone setup with each word
	stg_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.start_tone (start_tone),
		.full       (full),
		.cfg        (cfg_q),
		.cmd_pop    (cmd_pop),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd)
	);

	// divider for the half period
	stg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// back: tone state, envelope and phase
	stg_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.div_req   (div_req),
		.div_rsp   (div_rsp),
		.rslt_full (rslt_full),
		.rslt_push (rslt_push),
		.rslt      (rslt)
	);

	// output queue; head word sits on the result ports while empty is low
	stg_rslt_q u_rslt_q (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr       (rslt_push),
		.wr_data  (rslt),
		.wr_full  (rslt_full),
		.rd       (pop),
		.rd_empty (empty),
		.rd_data  (head)
	);

	assign sample_value = head.sample;
	assign last_sample  = head.last;
	assign tone_active  = head.active;

endmodule
